FILE: design/dqc_pkg.sv
// Shared types, codes and constant tables of the coefficient dequantizer.
package dqc_pkg;

    localparam int POS_W   = 10;
    localparam int COEF_W  = 16;
    localparam int QP_W    = 7;
    localparam int FACT_W  = 9;
    localparam int SHIFT_W = 4;
    localparam int BD_W    = 4;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_LUMA_BD    = 2'd0;
    localparam logic [1:0] CFG_CHROMA_BD  = 2'd1;
    localparam logic [1:0] CFG_SCALING_ON = 2'd2;

    localparam logic [1:0] COMP_LUMA = 2'd0;

    localparam logic [BD_W-1:0]   BD_MIN      = 4'd8;
    localparam logic [BD_W-1:0]   BD_MAX      = 4'd12;
    localparam logic [BD_W-1:0]   BD_RESET    = 4'd8;
    localparam logic [FACT_W-1:0] FLAT_FACTOR = 9'd16;

    localparam logic signed [COEF_W-1:0] COEF_MIN = 16'sh8000;
    localparam logic signed [COEF_W-1:0] COEF_MAX = 16'sh7FFF;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCALE,
        ST_DRAIN
    } dqc_state_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] level;
        logic [FACT_W-1:0]        factor;
        logic [QP_W-1:0]          qp;
        logic [SHIFT_W-1:0]       shift;
    } dqc_scale_req_t;

    // levelScale indexed by qp mod 6
    function automatic logic [6:0] level_scale(input logic [2:0] idx);
        logic [6:0] v;
        begin
            case (idx)
                3'd0:    v = 7'd40;
                3'd1:    v = 7'd45;
                3'd2:    v = 7'd51;
                3'd3:    v = 7'd57;
                3'd4:    v = 7'd64;
                3'd5:    v = 7'd72;
                default: v = 7'd40;
            endcase
            return v;
        end
    endfunction

    // qp / 6 by reciprocal multiply, exact for every 7-bit qp
    function automatic logic [4:0] qp_div6(input logic [QP_W-1:0] qp);
        logic [12:0] p;
        begin
            p = 13'(qp) * 13'd43;
            return p[12:8];
        end
    endfunction

endpackage

FILE: design/dqc_scaler.sv
// Four-stage pipelined inverse-quantization arithmetic with rounding and saturation.
module dqc_scaler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  dqc_pkg::dqc_scale_req_t      req,
    output logic                         res_valid,
    output logic signed [dqc_pkg::COEF_W-1:0] res
);

    localparam int P1_W = 26;
    localparam int P2_W = 31;
    localparam int SW   = 54;

    logic [3:0]               vld_reg;
    logic signed [P1_W-1:0]   p1_reg;
    logic [4:0]               k1_reg;
    logic [2:0]               rem1_reg;
    logic [dqc_pkg::SHIFT_W-1:0] sh1_reg;
    logic signed [P2_W-1:0]   p2_reg;
    logic [4:0]               k2_reg;
    logic [dqc_pkg::SHIFT_W-1:0] sh2_reg;
    logic signed [SW-1:0]     sum3_reg;
    logic [dqc_pkg::SHIFT_W-1:0] sh3_reg;
    logic signed [dqc_pkg::COEF_W-1:0] res_reg;

    logic [4:0]               quo;
    logic [2:0]               rem;
    logic signed [P1_W-1:0]   p1_next;
    logic signed [P1_W+7:0]   p2_full;
    logic signed [SW-1:0]     p2_ext;
    logic signed [SW-1:0]     sum3_next;
    logic signed [SW-1:0]     shifted;
    logic signed [dqc_pkg::COEF_W-1:0] res_next;

    always_comb
    begin
        quo      = dqc_pkg::qp_div6(req.qp);
        rem      = 3'(req.qp - 7'(quo) * 7'd6);
        p1_next  = P1_W'($signed(req.level)) * P1_W'($signed({1'b0, req.factor}));
        p2_full  = (P1_W+8)'(p1_reg)
                 * (P1_W+8)'($signed({1'b0, dqc_pkg::level_scale(rem1_reg)}));
        p2_ext   = {{(SW-P2_W){p2_reg[P2_W-1]}}, p2_reg};
        sum3_next = (p2_ext <<< k2_reg) + (SW'(1) << (sh2_reg - 4'd1));
        shifted  = sum3_reg >>> sh3_reg;
        if (shifted < SW'(dqc_pkg::COEF_MIN))
        begin
            res_next = dqc_pkg::COEF_MIN;
        end
        else if (shifted > SW'(dqc_pkg::COEF_MAX))
        begin
            res_next = dqc_pkg::COEF_MAX;
        end
        else
        begin
            res_next = shifted[dqc_pkg::COEF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[2:0], req_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= p1_next;
        k1_reg   <= quo;
        rem1_reg <= rem;
        sh1_reg  <= req.shift;
        p2_reg   <= P2_W'(p2_full);
        k2_reg   <= k1_reg;
        sh2_reg  <= sh1_reg;
        sum3_reg <= sum3_next;
        sh3_reg  <= sh2_reg;
        res_reg  <= res_next;
    end

    assign res_valid = vld_reg[3];
    assign res       = res_reg;

endmodule

FILE: design/dqc_store.sv
// Block coefficient store: one write port, one read port, registered read data.
module dqc_store #(
    parameter int AW = 10
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic [dqc_pkg::COEF_W-1:0]        wdata,
    input  logic                              re,
    input  logic [AW-1:0]                     raddr,
    output logic [dqc_pkg::COEF_W-1:0]        rdata
);

    localparam int DEPTH = 1 << AW;

    logic [dqc_pkg::COEF_W-1:0] mem [DEPTH];
    logic [dqc_pkg::COEF_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/hevc_coefficient_dequantizer_core.sv
// Top level of the coefficient dequantizer: command sequencer, config registers, block store.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------------
//  command  | start / busy           | cmd level position scale_factor qp log2_size
//           |                        | component bypass
//  result   | done (one-cycle pulse) | coefficient out_position block_end
//  config   | cfg_write              | cfg_index cfg_data
//
// A command transfers at a rising edge with start high and busy low.
// Load: accept, then the 4-stage scaler pipeline, then one store write.
// Drain: accept issues the store read, the next cycle writes the entry back to zero;
//   done pulses in the cycle after that, while busy is already low.
// Reset: the store's 2^(2*MAX_LOG2_BLOCK) entries (1024 at the default) are swept to
//   zero, one entry a cycle; busy stays high for the sweep, config writes go through.
// The receiver cannot stall; each result shows for exactly one cycle.
module hevc_coefficient_dequantizer_core #(
    parameter int MAX_LOG2_BLOCK = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cmd,
    input  logic signed [dqc_pkg::COEF_W-1:0]   level,
    input  logic [dqc_pkg::POS_W-1:0]           position,
    input  logic [7:0]                          scale_factor,
    input  logic [dqc_pkg::QP_W-1:0]            qp,
    input  logic [2:0]                          log2_size,
    input  logic [1:0]                          component,
    input  logic                                bypass,
    output logic                                done,
    output logic signed [dqc_pkg::COEF_W-1:0]   coefficient,
    output logic [dqc_pkg::POS_W-1:0]           out_position,
    output logic                                block_end,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [dqc_pkg::BD_W-1:0]            cfg_data
);

    localparam int AW = 2 * MAX_LOG2_BLOCK;
    localparam logic [2:0] LOG2_MAX = 3'(MAX_LOG2_BLOCK);
    localparam logic [2:0] LOG2_MIN = 3'd2;

    // configuration registers
    logic [dqc_pkg::BD_W-1:0] luma_bd_reg;
    logic [dqc_pkg::BD_W-1:0] chroma_bd_reg;
    logic                     scl_on_reg;

    // control state
    dqc_pkg::dqc_state_t state_reg, state_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                done_reg, done_next;

    // captured item and result payload
    logic signed [dqc_pkg::COEF_W-1:0] level_reg, level_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic                bypass_reg, bypass_next;
    logic                inrange_reg, inrange_next;
    logic                last_reg, last_next;
    logic signed [dqc_pkg::COEF_W-1:0] coef_reg, coef_next;
    logic [AW-1:0]       opos_reg, opos_next;
    logic                bend_reg, bend_next;

    // item decode
    logic                accept;
    logic [2:0]          log2_eff;
    logic [AW:0]         area;
    logic [dqc_pkg::BD_W-1:0] bd_sel;
    logic [dqc_pkg::BD_W-1:0] bd_eff;
    dqc_pkg::dqc_scale_req_t  sreq;
    logic                sreq_valid;
    logic                sres_valid;
    logic signed [dqc_pkg::COEF_W-1:0] sres;

    // store port
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [dqc_pkg::COEF_W-1:0] mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    logic [dqc_pkg::COEF_W-1:0] mem_rdata;

    assign busy   = (state_reg != dqc_pkg::ST_IDLE);
    assign accept = start && !busy;

    // clamp block size and bit depth, derive area and scaler request
    always_comb
    begin
        if (log2_size < LOG2_MIN)
        begin
            log2_eff = LOG2_MIN;
        end
        else if (log2_size > LOG2_MAX)
        begin
            log2_eff = LOG2_MAX;
        end
        else
        begin
            log2_eff = log2_size;
        end
        area   = (AW+1)'(1) << {log2_eff, 1'b0};
        bd_sel = (component == dqc_pkg::COMP_LUMA) ? luma_bd_reg : chroma_bd_reg;
        if (bd_sel < dqc_pkg::BD_MIN)
        begin
            bd_eff = dqc_pkg::BD_MIN;
        end
        else if (bd_sel > dqc_pkg::BD_MAX)
        begin
            bd_eff = dqc_pkg::BD_MAX;
        end
        else
        begin
            bd_eff = bd_sel;
        end
        sreq.level  = level;
        sreq.factor = scl_on_reg ? {1'b0, scale_factor} : dqc_pkg::FLAT_FACTOR;
        sreq.qp     = qp;
        sreq.shift  = dqc_pkg::SHIFT_W'(5'(bd_eff) + 5'(log2_eff) - 5'd5);
        sreq_valid  = accept && (cmd == dqc_pkg::CMD_LOAD);
    end

    // sequencer: next state, store accesses and result
    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        level_next   = level_reg;
        pos_next     = pos_reg;
        bypass_next  = bypass_reg;
        inrange_next = inrange_reg;
        last_next    = last_reg;
        coef_next    = coef_reg;
        opos_next    = opos_reg;
        bend_next    = bend_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = ptr_reg;

        case (state_reg)
            dqc_pkg::ST_CLEAR:
            begin
                // sweep the store to zero after reset
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == {AW{1'b1}})
                begin
                    state_next = dqc_pkg::ST_IDLE;
                end
            end
            dqc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == dqc_pkg::CMD_DRAIN)
                    begin
                        mem_re     = 1'b1;
                        last_next  = ({1'b0, ptr_reg} >= (area - (AW+1)'(1)));
                        state_next = dqc_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        level_next   = level;
                        pos_next     = position[AW-1:0];
                        bypass_next  = bypass;
                        inrange_next = ({1'b0, position} < 11'(area));
                        state_next   = dqc_pkg::ST_SCALE;
                    end
                end
            end
            dqc_pkg::ST_SCALE:
            begin
                // wait for the scaler, then write; drop loads outside the block
                if (sres_valid)
                begin
                    mem_we     = inrange_reg;
                    mem_waddr  = pos_reg;
                    mem_wdata  = bypass_reg ? level_reg : sres;
                    state_next = dqc_pkg::ST_IDLE;
                end
            end
            dqc_pkg::ST_DRAIN:
            begin
                // read data is here: emit it and clear the entry behind it
                coef_next  = mem_rdata;
                opos_next  = ptr_reg;
                bend_next  = last_reg;
                done_next  = 1'b1;
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg;
                mem_wdata  = '0;
                ptr_next   = last_reg ? '0 : ptr_reg + AW'(1);
                state_next = dqc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dqc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dqc_pkg::ST_CLEAR;
            ptr_reg     <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        level_reg   <= level_next;
        pos_reg     <= pos_next;
        bypass_reg  <= bypass_next;
        inrange_reg <= inrange_next;
        last_reg    <= last_next;
        coef_reg    <= coef_next;
        opos_reg    <= opos_next;
        bend_reg    <= bend_next;
    end

    // configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_bd_reg   <= dqc_pkg::BD_RESET;
            chroma_bd_reg <= dqc_pkg::BD_RESET;
            scl_on_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dqc_pkg::CFG_LUMA_BD:    luma_bd_reg   <= cfg_data;
                dqc_pkg::CFG_CHROMA_BD:  chroma_bd_reg <= cfg_data;
                dqc_pkg::CFG_SCALING_ON: scl_on_reg    <= cfg_data[0];
                default:                 scl_on_reg    <= scl_on_reg;
            endcase
        end
    end

    dqc_scaler u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (sreq_valid),
        .req       (sreq),
        .res_valid (sres_valid),
        .res       (sres)
    );

    dqc_store #(
        .AW (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign done         = done_reg;
    assign coefficient  = coef_reg;
    assign out_position = dqc_pkg::POS_W'(opos_reg);
    assign block_end    = bend_reg;

endmodule

FILE: design/dqc_checker.sv
// Port-level checker for the coefficient dequantizer and its bind.
module dqc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cmd,
    input logic done
);

    // every accepted command occupies the sequencer in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // every result follows a matching drain transfer, through the drain state and the done register
    a_done_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy, 2) && ($past(cmd, 2) == dqc_pkg::CMD_DRAIN)))
        else $error("result without a matching drain transfer");

    // a drain transfer always yields its result
    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == dqc_pkg::CMD_DRAIN)) |=> ##1 done)
        else $error("drain transfer lost its result");

    // results are single-cycle pulses
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

endmodule

bind hevc_coefficient_dequantizer_core dqc_checker u_dqc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);
